// File: sv/u16u8_pkg.sv
// shared types, constants and byte encoder for the utf-16 to utf-8 transcoder
`default_nettype none
package u16u8_pkg;

    // surrogate ranges, tested on the upper six bits of a code unit
    localparam logic [5:0]  HI_TAG     = 6'b110110;
    localparam logic [5:0]  LO_TAG     = 6'b110111;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;
    localparam logic [15:0] LIM_ONE    = 16'h0080;
    localparam logic [15:0] LIM_TWO    = 16'h0800;
    localparam logic [7:0]  LEAD_TWO   = 8'hC0;
    localparam logic [7:0]  LEAD_THREE = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR  = 8'hF0;
    localparam logic [7:0]  CONT_MARK  = 8'h80;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    // encoded length of one character, code is byte count minus one
    typedef enum logic [1:0] {
        LEN_1 = 2'd0,
        LEN_2 = 2'd1,
        LEN_3 = 2'd2,
        LEN_4 = 2'd3
    } t_len;

    typedef struct packed {
        logic [20:0] cp;
        t_len        len;
    } t_char;

    typedef struct packed {
        logic  push;
        t_char data;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // byte idx of the utf-8 encoding of a code point
    function automatic logic [7:0] enc_byte(input t_char c, input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (c.len)
            LEN_1: b = {1'b0, c.cp[6:0]};
            LEN_2: begin
                case (idx)
                    2'd0:    b = LEAD_TWO | {3'b000, c.cp[10:6]};
                    default: b = CONT_MARK | {2'b00, c.cp[5:0]};
                endcase
            end
            LEN_3: begin
                case (idx)
                    2'd0:    b = LEAD_THREE | {4'b0000, c.cp[15:12]};
                    2'd1:    b = CONT_MARK | {2'b00, c.cp[11:6]};
                    default: b = CONT_MARK | {2'b00, c.cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = LEAD_FOUR | {5'b00000, c.cp[20:18]};
                    2'd1:    b = CONT_MARK | {2'b00, c.cp[17:12]};
                    2'd2:    b = CONT_MARK | {2'b00, c.cp[11:6]};
                    default: b = CONT_MARK | {2'b00, c.cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// File: sv/utf16_to_utf8_transcoder_top.sv
// top level of the utf-16 to utf-8 transcoder
//
// channel   dir  payload                                     ends with
// s_axis    in   tdata[15:0] code_unit, tlast end_of_string  tvalid && tready
// m_axis    out  tdata[7:0] utf8_byte, tlast char_done       tvalid && tready
//
// one output byte per cycle unless the output stalls or the queue is empty; a bmp
// unit gives 1 to 3 bytes, a surrogate pair 4 over its two units; the back end's serializer sets this rate
// input units enter every cycle while the 4-entry character queue has room
// output byte to first byte of the next character needs no bubble
// reset is synchronous, active low, and clears the held surrogate and the queue
// a stalled output holds its byte in the output register while the front goes on
`default_nettype none
module utf16_to_utf8_transcoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  wire logic        s_axis_tlast,   // end_of_string
    // master side
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [7:0]  m_axis_tdata,   // [7:0] utf8_byte
    output      logic        m_axis_tlast    // char_done
);

    u16u8_pkg::t_push     w_push;
    u16u8_pkg::t_char     w_head;
    u16u8_pkg::t_q_status w_q_status;
    logic                 w_pop;

    // classify units, hold high surrogates, build code points
    u16u8_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_unit     (s_axis_tdata),
        .i_eos      (s_axis_tlast),
        .i_q_status (w_q_status),
        .o_ready    (s_axis_tready),
        .o_push     (w_push)
    );

    // decouples unit intake from byte output
    u16u8_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // emits one byte per cycle into the output register unless the output stalls or the queue is empty
    u16u8_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .i_ready    (m_axis_tready),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .o_byte     (m_axis_tdata),
        .o_last     (m_axis_tlast)
    );

    // queue status never claims full and empty at once
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue full and empty together");

    // a character leaves the queue only when one is there
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty queue");

    // nothing is offered right after reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

// File: sv/u16u8_front.sv
// front end: accepts code units, pairs surrogates and queues whole characters
`default_nettype none
module u16u8_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [15:0]           i_unit,
    input  wire logic                  i_eos,
    input  wire u16u8_pkg::t_q_status  i_q_status,
    output      logic                  o_ready,
    output      u16u8_pkg::t_push      o_push
);

    logic       r_pending;
    logic [9:0] r_held;
    logic       n_pending;
    logic [9:0] n_held;
    logic       w_acc;
    logic       w_is_high;
    logic       w_is_low;
    logic       w_pair;

    assign o_ready   = !i_q_status.full;
    assign w_acc     = i_valid && o_ready;
    assign w_is_high = (i_unit[15:10] == u16u8_pkg::HI_TAG);
    assign w_is_low  = (i_unit[15:10] == u16u8_pkg::LO_TAG);
    assign w_pair    = r_pending && w_is_low;

    always_comb begin
        o_push = '0;
        o_push.push = w_acc && (w_pair || (!w_is_high && !w_is_low));
        if (w_pair) begin
            o_push.data.cp  = u16u8_pkg::SUPP_BASE + {1'b0, r_held, i_unit[9:0]};
            o_push.data.len = u16u8_pkg::LEN_4;
        end else begin
            o_push.data.cp = {5'b00000, i_unit};
            if (i_unit < u16u8_pkg::LIM_ONE) begin
                o_push.data.len = u16u8_pkg::LEN_1;
            end else if (i_unit < u16u8_pkg::LIM_TWO) begin
                o_push.data.len = u16u8_pkg::LEN_2;
            end else begin
                o_push.data.len = u16u8_pkg::LEN_3;
            end
        end
    end

    // a held high surrogate lives for exactly one following unit
    always_comb begin
        n_pending = r_pending;
        n_held    = r_held;
        if (w_acc) begin
            n_pending = w_is_high && !i_eos;
            n_held    = (w_is_high && !i_eos) ? i_unit[9:0] : 10'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_held    <= 10'd0;
        end else begin
            r_pending <= n_pending;
            r_held    <= n_held;
        end
    end

endmodule
`default_nettype wire

// File: sv/u16u8_queue.sv
// small character queue between front and back
`default_nettype none
module u16u8_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire u16u8_pkg::t_push      i_push,
    input  wire logic                  i_pop,
    output      u16u8_pkg::t_char      o_head,
    output      u16u8_pkg::t_q_status  o_status
);

    localparam int unsigned CW = u16u8_pkg::Q_AW + 1;

    u16u8_pkg::t_char              r_mem [u16u8_pkg::Q_DEPTH];
    logic [u16u8_pkg::Q_AW-1:0]    r_wptr;
    logic [u16u8_pkg::Q_AW-1:0]    r_rptr;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;

    assign o_head         = r_mem[r_rptr];
    assign o_status.full  = (r_count == CW'(u16u8_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_push.push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// File: sv/u16u8_back.sv
// back end: serializes each queued character into utf-8 bytes
`default_nettype none
module u16u8_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire u16u8_pkg::t_char      i_head,
    input  wire u16u8_pkg::t_q_status  i_q_status,
    input  wire logic                  i_ready,
    output      logic                  o_pop,
    output      logic                  o_valid,
    output      logic [7:0]            o_byte,
    output      logic                  o_last
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       w_load;
    logic       w_is_last;

    assign w_load    = !i_q_status.empty && (!r_valid || i_ready);
    assign w_is_last = (r_idx == 2'(i_head.len));
    assign o_pop     = w_load && w_is_last;
    assign o_valid   = r_valid;
    assign o_byte    = r_byte;
    assign o_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= u16u8_pkg::enc_byte(i_head, r_idx);
            r_last <= w_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_is_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// self-checking testbench for the utf-16 to utf-8 transcoder
`timescale 1ns / 1ps
module tb_top;

    // utf-16 tags and utf-8 encoding constants, kept local to the bench
    localparam logic [5:0]  TAG_HIGH    = 6'b110110;
    localparam logic [5:0]  TAG_LOW     = 6'b110111;
    localparam logic [20:0] PLANE1_BASE = 21'h10000;
    localparam logic [7:0]  LEAD2       = 8'hC0;
    localparam logic [7:0]  LEAD3       = 8'hE0;
    localparam logic [7:0]  LEAD4       = 8'hF0;
    localparam logic [7:0]  CONT        = 8'h80;
    localparam int          USE_MODEL   = -1;   // row expectation comes from the predictor
    localparam int          RANDOM_UNITS = 336;
    localparam int          DRAIN_CYCLES = 20;

    // one directed row; enc holds the expected bytes, first byte in the highest used lane
    typedef struct {
        logic [15:0] cu;
        logic        eos;
        int          nbytes;
        logic [31:0] enc;
    } t_dir_row;

    // what one accepted code unit should produce
    typedef struct {
        int          nbytes;
        logic [31:0] enc;
    } t_unit_plan;

    typedef struct packed {
        logic [7:0] octet;
        logic       done;
    } t_utf8_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'h0000;   // [15:0] code_unit
    logic        s_axis_tlast = 1'b0;       // end_of_string
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;              // [7:0] utf8_byte
    logic        m_axis_tlast;              // char_done

    // predictor state: the high surrogate waiting for its partner
    logic [9:0]  held_hi_bits = 10'd0;
    logic        hi_waiting = 1'b0;

    t_unit_plan  unit_plans[$];
    t_utf8_out   utf8_expected[$];

    int          error_count = 0;
    int          units_sent = 0;
    int          units_seen = 0;
    int          bytes_checked = 0;
    int          pairs_joined = 0;
    int          strings_sent = 0;
    bit          src_quiet = 1'b0;
    bit          snk_quiet = 1'b0;

    // directed rows: range edges, surrogate pairing and every dropping rule
    t_dir_row dir_rows [0:23] = '{
        '{16'h0000, 1'b0, 1, 32'h0000_0000},    // smallest unit
        '{16'h007F, 1'b0, 1, 32'h0000_007F},    // top of one-byte range
        '{16'h0080, 1'b0, 2, 32'h0000_C280},    // first two-byte char
        '{16'h07FF, 1'b0, 2, 32'h0000_DFBF},    // top of two-byte range
        '{16'h0800, 1'b0, 3, 32'h00E0_A080},    // first three-byte char
        '{16'hFFFF, 1'b0, 3, 32'h00EF_BFBF},    // largest unit
        '{16'hD7FF, 1'b0, 3, 32'h00ED_9FBF},    // just below the surrogates
        '{16'hE000, 1'b0, 3, 32'h00EE_8080},    // just above the surrogates
        '{16'hDC00, 1'b0, 0, 32'h0000_0000},    // lone low surrogate, dropped
        '{16'hDFFF, 1'b0, 0, 32'h0000_0000},    // lone low surrogate, dropped
        '{16'hD800, 1'b0, 0, 32'h0000_0000},    // high held
        '{16'hDC00, 1'b0, 4, 32'hF090_8080},    // lowest supplementary point
        '{16'hDBFF, 1'b0, 0, 32'h0000_0000},    // high held
        '{16'hDFFF, 1'b0, 4, 32'hF48F_BFBF},    // highest supplementary point
        '{16'hD800, 1'b0, 0, 32'h0000_0000},    // high held, then broken by a plain char
        '{16'h0041, 1'b0, 1, 32'h0000_0041},    // held high dropped silently
        '{16'hDA00, 1'b1, 0, 32'h0000_0000},    // high at end of string, discarded
        '{16'hDC00, 1'b0, 0, 32'h0000_0000},    // nothing held any more, so a lone low
        '{16'hD83D, 1'b0, 0, 32'h0000_0000},    // high held
        '{16'hDBFF, 1'b0, 0, 32'h0000_0000},    // second high replaces the first
        '{16'hDE00, 1'b0, USE_MODEL, 32'h0},    // pairs with the second high
        '{16'hD83D, 1'b0, 0, 32'h0000_0000},    // high held
        '{16'hDE00, 1'b1, USE_MODEL, 32'h0},    // pair closing the string
        '{16'h20AC, 1'b1, 3, 32'h00E2_82AC}     // three-byte char with end of string
    };

    utf16_to_utf8_transcoder_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // encodes one code unit against the held surrogate and advances that state
    task automatic transcode_unit(input logic [15:0] cu, input logic eos,
                                  output int nbytes, output logic [31:0] enc);
        logic        is_hi;
        logic        is_lo;
        logic [20:0] cp;
        is_hi = (cu[15:10] == TAG_HIGH);
        is_lo = (cu[15:10] == TAG_LOW);
        nbytes = 0;
        enc = 32'd0;
        cp = 21'd0;
        if (hi_waiting && is_lo) begin
            cp = PLANE1_BASE + {1'b0, held_hi_bits, 10'd0} + {11'd0, cu[9:0]};
            nbytes = 4;
        end else if (!is_hi && !is_lo) begin
            cp = {5'd0, cu};
            nbytes = (cu < 16'h0080) ? 1 : (cu < 16'h0800) ? 2 : 3;
        end
        // a high only stays held when it does not close the string
        hi_waiting = is_hi && !eos;
        held_hi_bits = (is_hi && !eos) ? cu[9:0] : 10'd0;
        case (nbytes)
            1: enc = {25'd0, cp[6:0]};
            2: enc = {16'd0, LEAD2 | {3'd0, cp[10:6]}, CONT | {2'd0, cp[5:0]}};
            3: enc = {8'd0, LEAD3 | {4'd0, cp[15:12]}, CONT | {2'd0, cp[11:6]},
                      CONT | {2'd0, cp[5:0]}};
            4: enc = {LEAD4 | {5'd0, cp[20:18]}, CONT | {2'd0, cp[17:12]},
                      CONT | {2'd0, cp[11:6]}, CONT | {2'd0, cp[5:0]}};
            default: enc = 32'd0;
        endcase
    endtask

    // offers one code unit after a random gap and waits for its handshake
    task automatic send_unit(input logic [15:0] cu, input logic eos,
                             input int nbytes, input logic [31:0] enc);
        int         gap;
        t_unit_plan plan;
        gap = src_quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        plan.nbytes = nbytes;
        plan.enc = enc;
        unit_plans.push_back(plan);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= cu;
        s_axis_tlast <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        units_sent++;
    endtask

    // one random utf-16 character, mostly valid, sometimes broken
    task automatic pick_char(ref logic [15:0] str[$]);
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(0, 11))
            0, 1, 2: str.push_back(16'($urandom_range(0, 16'h007F)));
            3:       str.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
            4:       str.push_back(16'($urandom_range(16'h0800, 16'hD7FF)));
            5:       str.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
            6, 7, 8: begin
                // well-formed surrogate pair with random payload
                str.push_back({TAG_HIGH, r[9:0]});
                str.push_back({TAG_LOW, 10'($urandom)});
            end
            9:       str.push_back({TAG_LOW, r[9:0]});     // stray low
            10:      str.push_back({TAG_HIGH, r[9:0]});    // stray high
            default: str.push_back(r);                     // any unit at all
        endcase
    endtask

    task automatic send_string();
        logic [15:0] str[$];
        int          nchars;
        nchars = $urandom_range(1, 8);
        repeat (nchars) pick_char(str);
        foreach (str[i]) send_unit(str[i], (i == str.size() - 1), USE_MODEL, 32'd0);
        strings_sent++;
    endtask

    // scoreboard: predicts on accepted input units, then checks accepted output bytes
    always @(posedge i_clk) begin : scoreboard
        t_unit_plan  plan;
        int          nbytes;
        logic [31:0] enc;
        t_utf8_out   want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                plan = unit_plans.pop_front();
                transcode_unit(s_axis_tdata, s_axis_tlast, nbytes, enc);
                if (plan.nbytes != USE_MODEL) begin
                    nbytes = plan.nbytes;
                    enc = plan.enc;
                end
                if (nbytes == 4) pairs_joined++;
                for (int k = 0; k < nbytes; k++) begin
                    want.octet = enc[8 * (nbytes - 1 - k) +: 8];
                    want.done = (k == nbytes - 1);
                    utf8_expected.push_back(want);
                end
                units_seen++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (utf8_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h done %0b",
                                              m_axis_tdata, m_axis_tlast));
                end else begin
                    want = utf8_expected.pop_front();
                    if (m_axis_tdata !== want.octet)
                        report_mismatch($sformatf("utf8_byte %02h, want %02h",
                                                  m_axis_tdata, want.octet));
                    if (m_axis_tlast !== want.done)
                        report_mismatch($sformatf("char_done %0b, want %0b on byte %02h",
                                                  m_axis_tlast, want.done, want.octet));
                end
                bytes_checked++;
            end
        end
    end

    // output side: random stall before each byte, with stall-free stretches
    initial begin : byte_sink
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = snk_quiet ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // switches either side in and out of back-to-back mode now and then
    initial begin : pacing
        forever begin
            repeat ($urandom_range(40, 250)) @(posedge i_clk);
            src_quiet = ($urandom_range(0, 3) == 0);
            snk_quiet = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_unit(dir_rows[i].cu, dir_rows[i].eos, dir_rows[i].nbytes, dir_rows[i].enc);

        while (units_sent < RANDOM_UNITS + $size(dir_rows)) send_string();
        s_axis_tvalid <= 1'b0;

        // drain everything predicted, then watch for stray bytes
        @(posedge i_clk);
        while (utf8_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d code units (%0d directed, %0d random strings), %0d pairs joined",
                 units_seen, $size(dir_rows), strings_sent, pairs_joined);
        $display("checked %0d utf-8 bytes, %0d mismatches", bytes_checked, error_count);
        if (error_count == 0 && utf8_expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #5000000;
        $display("timeout with %0d bytes still expected", utf8_expected.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
